FILE: hw/rtl/motion_vector_subpel_sample_address_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sub-pel sample address core
// Shared shorthand for clocked, reset-qualified assertions.
// ----------------------------------------------------------------------------
`ifndef MOTION_VECTOR_SUBPEL_SAMPLE_ADDRESS_CORE_MACROS_SVH
`define MOTION_VECTOR_SUBPEL_SAMPLE_ADDRESS_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define MVSA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mvsa assertion failed");

// Next-cycle implication, checked on every rising edge out of reset.
`define MVSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mvsa assertion failed");

`endif

FILE: hw/rtl/mvsa_pkg.sv
// ----------------------------------------------------------------------------
// mvsa_pkg
// Types, widths and codes shared by the sub-pel sample address core.
// ----------------------------------------------------------------------------
package mvsa_pkg;

  localparam int VecW      = 16;
  localparam int TsW       = 9;
  localparam int ShW       = 2;
  localparam int PadW      = 10;
  localparam int DimW      = 13;
  localparam int PixW      = 12;
  localparam int SrcW      = 17;
  localparam int PhaseW    = 4;
  localparam int SlotW     = 4;
  localparam int LimW      = 16;
  localparam int ProdW     = 26;
  localparam int ScaledW   = 18;
  localparam int SumW      = 19;
  localparam int CfgAddrW  = 3;
  localparam int CfgDataW  = 13;
  localparam int InDataW   = 72;
  localparam int OutDataW  = 64;

  localparam int MaxFrameDim      = 4096;
  localparam int PhaseSlotsDefault = 16;
  localparam int RoundHalf        = 128;
  localparam int ScaleShift       = 8;

  typedef enum logic {
    FuncSample = 1'b0,
    FuncLoad   = 1'b1
  } func_e;

  typedef enum logic [CfgAddrW-1:0] {
    RegTimeScale    = 3'd0,
    RegRoundNearest = 3'd1,
    RegSubpelShift  = 3'd2,
    RegPadLeft      = 3'd3,
    RegPadTop       = 3'd4,
    RegFrameColumns = 3'd5,
    RegFrameRows    = 3'd6
  } cfg_reg_e;

  // Raster position of the next sample, with its last-column and last-row flags.
  typedef struct packed {
    logic [PixW-1:0] col;
    logic [PixW-1:0] row;
    logic            last_col;
    logic            last_row;
  } raster_pos_t;

endpackage

FILE: hw/rtl/mvsa_raster.sv
// ----------------------------------------------------------------------------
// mvsa_raster
// Column and row counters that walk the vector field in raster order.
// ----------------------------------------------------------------------------
module mvsa_raster (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      advance_i,
  input  logic [mvsa_pkg::DimW-1:0] frame_columns_i,
  input  logic [mvsa_pkg::DimW-1:0] frame_rows_i,
  output mvsa_pkg::raster_pos_t     pos_o
);
  import mvsa_pkg::*;

  logic [PixW-1:0] col_q, col_d;
  logic [PixW-1:0] row_q, row_d;
  logic [DimW-1:0] cols, rows;
  logic            last_col, last_row;

  // Zero counts as one; anything past the largest frame saturates.
  function automatic logic [DimW-1:0] frame_limit(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > DimW'(MaxFrameDim)) begin
      r = DimW'(MaxFrameDim);
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign cols     = frame_limit(frame_columns_i);
  assign rows     = frame_limit(frame_rows_i);
  assign last_col = ({1'b0, col_q} + DimW'(1)) >= cols;
  assign last_row = ({1'b0, row_q} + DimW'(1)) >= rows;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (advance_i) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + PixW'(1);
      end else begin
        col_d = col_q + PixW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign pos_o = '{col: col_q, row: row_q, last_col: last_col, last_row: last_row};

endmodule

FILE: hw/rtl/mvsa_phase_table.sv
// ----------------------------------------------------------------------------
// mvsa_phase_table
// Valid width and height of each sub-pel phase plane, filled by load items.
// ----------------------------------------------------------------------------
module mvsa_phase_table #(
  parameter int PHASE_SLOTS = mvsa_pkg::PhaseSlotsDefault
) (
  input  logic                        clk_i,
  input  logic                        wr_en_i,
  input  logic [mvsa_pkg::SlotW-1:0]  wr_slot_i,
  input  logic [mvsa_pkg::LimW-1:0]   wr_width_i,
  input  logic [mvsa_pkg::LimW-1:0]   wr_height_i,
  input  logic [mvsa_pkg::PhaseW-1:0] rd_phase_i,
  output logic                        rd_hit_o,
  output logic [mvsa_pkg::LimW-1:0]   rd_width_o,
  output logic [mvsa_pkg::LimW-1:0]   rd_height_o
);
  import mvsa_pkg::*;

  localparam int IdxW = (PHASE_SLOTS > 1) ? $clog2(PHASE_SLOTS) : 1;

  logic [LimW-1:0] width_q  [PHASE_SLOTS];
  logic [LimW-1:0] height_q [PHASE_SLOTS];
  logic            wr_hit;

  // Slots at or beyond the table depth are dropped on write and miss on read.
  assign wr_hit   = {1'b0, wr_slot_i} < (SlotW + 1)'(PHASE_SLOTS);
  assign rd_hit_o = {1'b0, rd_phase_i} < (PhaseW + 1)'(PHASE_SLOTS);

  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_hit) begin
      width_q[wr_slot_i[IdxW-1:0]]  <= wr_width_i;
      height_q[wr_slot_i[IdxW-1:0]] <= wr_height_i;
    end
  end

  assign rd_width_o  = rd_hit_o ? width_q[rd_phase_i[IdxW-1:0]]  : '0;
  assign rd_height_o = rd_hit_o ? height_q[rd_phase_i[IdxW-1:0]] : '0;

endmodule

FILE: hw/rtl/motion_vector_subpel_sample_address_core.sv
// ----------------------------------------------------------------------------
// motion_vector_subpel_sample_address_core
// Turns per-pixel motion vectors into padded whole-pel source addresses,
// sub-pel phase indexes and an in-domain flag, in raster order.
// ----------------------------------------------------------------------------
//
//   Channel   Dir  Handshake                   Payload
//   s_axis    in   s_axis_tvalid/tready        tdata: vectors, load entry; tuser: func
//   m_axis    out  m_axis_tvalid/tready        tdata: addresses, phase, flag; tlast: eof
//   cfg       in   cfg_valid_i/cfg_ready_o     cfg_addr_i register index, cfg_data_i
//
// An accepted item is registered in the input stage, where the multiply, the
// rounding shift, the address adds and the table compare happen, and is then
// held in the output register; one item per cycle while m_axis does not stall.
// A load item writes the phase table when it leaves the input stage and
// yields no result. Reset clears the counters, the configuration and both
// stage valid bits; the phase table holds no reset value. A stall on m_axis
// backs up into s_axis only once both stages are full.
// ----------------------------------------------------------------------------
`include "motion_vector_subpel_sample_address_core_macros.svh"

module motion_vector_subpel_sample_address_core #(
  parameter int PHASE_SLOTS = mvsa_pkg::PhaseSlotsDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input items.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata from bit 0: vector_x[16], vector_y[16], slot[4], slot_width[16],
  // slot_height[16], four zero bits.
  input  logic [mvsa_pkg::InDataW-1:0]    s_axis_tdata,
  // tuser: func (0 sample, 1 load a phase table entry).
  input  logic                            s_axis_tuser,
  // Result items.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata from bit 0: pixel_column[12], pixel_row[12], source_column[17],
  // source_row[17], phase_index[4], in_domain[1], one zero bit.
  output logic [mvsa_pkg::OutDataW-1:0]   m_axis_tdata,
  // tlast: end_of_frame.
  output logic                            m_axis_tlast,
  // Configuration writes.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mvsa_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  logic [mvsa_pkg::CfgDataW-1:0]   cfg_data_i
);
  import mvsa_pkg::*;

  // Configuration registers.
  logic [TsW-1:0]  time_scale_q;
  logic            round_nearest_q;
  logic [ShW-1:0]  subpel_shift_q;
  logic [PadW-1:0] pad_left_q, pad_top_q;
  logic [DimW-1:0] frame_columns_q, frame_rows_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_scale_q    <= TsW'(256);
      round_nearest_q <= 1'b0;
      subpel_shift_q  <= '0;
      pad_left_q      <= '0;
      pad_top_q       <= '0;
      frame_columns_q <= DimW'(1);
      frame_rows_q    <= DimW'(1);
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        RegTimeScale:    time_scale_q    <= cfg_data_i[TsW-1:0];
        RegRoundNearest: round_nearest_q <= cfg_data_i[0];
        RegSubpelShift:  subpel_shift_q  <= cfg_data_i[ShW-1:0];
        RegPadLeft:      pad_left_q      <= cfg_data_i[PadW-1:0];
        RegPadTop:       pad_top_q       <= cfg_data_i[PadW-1:0];
        RegFrameColumns: frame_columns_q <= cfg_data_i;
        RegFrameRows:    frame_rows_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake and stage control.
  logic s1_valid_q;
  logic s1_adv;
  logic s_acc;
  logic smp_acc;
  logic m_valid_q;

  func_e             s1_func_q;
  logic signed [VecW-1:0] s1_vx_q, s1_vy_q;
  logic [SlotW-1:0]  s1_slot_q;
  logic [LimW-1:0]   s1_sw_q, s1_sh_q;
  logic [PixW-1:0]   s1_col_q, s1_row_q;
  logic              s1_eof_q;

  raster_pos_t pos;

  // A load item leaves the input stage freely; a sample needs a free output slot.
  assign s1_adv  = s1_valid_q && ((s1_func_q == FuncLoad) || !m_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign s_acc   = s_axis_tvalid && s_axis_tready;
  assign smp_acc = s_acc && (func_e'(s_axis_tuser) == FuncSample);

  mvsa_raster u_raster (
    .clk_i,
    .rst_ni,
    .advance_i       (smp_acc),
    .frame_columns_i (frame_columns_q),
    .frame_rows_i    (frame_rows_q),
    .pos_o           (pos)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  // The raster position is snapshotted as the item enters.
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_func_q <= func_e'(s_axis_tuser);
      s1_vx_q   <= $signed(s_axis_tdata[15:0]);
      s1_vy_q   <= $signed(s_axis_tdata[31:16]);
      s1_slot_q <= s_axis_tdata[35:32];
      s1_sw_q   <= s_axis_tdata[51:36];
      s1_sh_q   <= s_axis_tdata[67:52];
      s1_col_q  <= pos.col;
      s1_row_q  <= pos.row;
      s1_eof_q  <= pos.last_col && pos.last_row;
    end
  end

  // Phase table: written as a load item leaves, read by the sample in stage 1.
  logic [PhaseW-1:0] phase;
  logic              tbl_hit;
  logic [LimW-1:0]   tbl_width, tbl_height;

  mvsa_phase_table #(
    .PHASE_SLOTS (PHASE_SLOTS)
  ) u_phase_table (
    .clk_i,
    .wr_en_i     (s1_adv && (s1_func_q == FuncLoad)),
    .wr_slot_i   (s1_slot_q),
    .wr_width_i  (s1_sw_q),
    .wr_height_i (s1_sh_q),
    .rd_phase_i  (phase),
    .rd_hit_o    (tbl_hit),
    .rd_width_o  (tbl_width),
    .rd_height_o (tbl_height)
  );

  // Scale each component by the time coefficient, optionally add one half,
  // and floor-shift by eight; the top bits of the sum are that floor.
  logic [ShW-1:0]            sh_eff;
  logic signed [ProdW-1:0]   ts_ext, half, sum_x, sum_y;
  logic signed [ScaledW-1:0] dx, dy, whole_x, whole_y;
  logic [PhaseW-1:0]         frac_x, frac_y;
  logic signed [SumW-1:0]    sx, sy;
  logic                      col_in, row_in, in_domain;

  // The unused precision code saturates to quarter pel.
  assign sh_eff = (subpel_shift_q == 2'd3) ? 2'd2 : subpel_shift_q;
  assign ts_ext = $signed(ProdW'(time_scale_q));
  assign half   = round_nearest_q ? ProdW'(RoundHalf) : '0;
  assign sum_x  = ProdW'(s1_vx_q) * ts_ext + half;
  assign sum_y  = ProdW'(s1_vy_q) * ts_ext + half;
  assign dx     = sum_x[ProdW-1:ScaleShift];
  assign dy     = sum_y[ProdW-1:ScaleShift];

  // Low sh_eff bits of each scaled component form the phase.
  always_comb begin
    case (sh_eff)
      2'd1: begin
        frac_x = PhaseW'(dx[0]);
        frac_y = PhaseW'(dy[0]);
      end
      2'd2: begin
        frac_x = PhaseW'(dx[1:0]);
        frac_y = PhaseW'(dy[1:0]);
      end
      default: begin
        frac_x = '0;
        frac_y = '0;
      end
    endcase
  end

  assign phase   = frac_x + (frac_y << sh_eff);
  assign whole_x = dx >>> sh_eff;
  assign whole_y = dy >>> sh_eff;

  // Padded whole-pel source position at full precision.
  assign sx = $signed(SumW'(pad_left_q)) + $signed(SumW'(s1_col_q)) + SumW'(whole_x);
  assign sy = $signed(SumW'(pad_top_q)) + $signed(SumW'(s1_row_q)) + SumW'(whole_y);

  // A nonnegative position stays below 2^17, so the low bits suffice for the compare.
  assign col_in    = !sx[SumW-1] && (sx[SumW-2:0] < (SumW - 1)'(tbl_width));
  assign row_in    = !sy[SumW-1] && (sy[SumW-2:0] < (SumW - 1)'(tbl_height));
  assign in_domain = tbl_hit && col_in && row_in;

  // Output register.
  logic [PixW-1:0]   o_col_q, o_row_q;
  logic [SrcW-1:0]   o_sx_q, o_sy_q;
  logic [PhaseW-1:0] o_phase_q;
  logic              o_in_q, o_eof_q;
  logic              s1_out;

  assign s1_out = s1_adv && (s1_func_q == FuncSample);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s1_out) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_out) begin
      o_col_q   <= s1_col_q;
      o_row_q   <= s1_row_q;
      o_sx_q    <= sx[SrcW-1:0];
      o_sy_q    <= sy[SrcW-1:0];
      o_phase_q <= phase;
      o_in_q    <= in_domain;
      o_eof_q   <= s1_eof_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, o_in_q, o_phase_q, o_sy_q, o_sx_q, o_row_q, o_col_q};
  assign m_axis_tlast  = o_eof_q;

  // A result appears only right after a sample item left the input stage.
  `MVSA_ASSERT_IMP(a_result_from_sample, $rose(m_valid_q),
                   $past(s1_valid_q && (s1_func_q == FuncSample)))
  // An in-domain result always carries nonnegative source coordinates.
  `MVSA_ASSERT_IMP(a_in_domain_nonneg, m_valid_q && o_in_q, !o_sx_q[SrcW-1] && !o_sy_q[SrcW-1])
  // The last pixel of a frame sends the raster back to the origin.
  `MVSA_ASSERT_NEXT(a_frame_wrap, smp_acc && pos.last_col && pos.last_row,
                    (pos.col == '0) && (pos.row == '0))
  // Back-pressure on the input only ever comes from a held input stage.
  `MVSA_ASSERT_IMP(a_stall_source, !s_axis_tready, s1_valid_q && m_valid_q)

endmodule

FILE: dv/tb_motion_vector_subpel_sample_address_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sub-pel sample address core testbench
// Loads the phase table, drives sample items through several register
// settings and compares every result item, field by field, against a
// cycle-free model of the address arithmetic and the raster counters.
// ----------------------------------------------------------------------------
module tb_motion_vector_subpel_sample_address_core;
  import mvsa_pkg::*;

  localparam int PhaseSlots    = PhaseSlotsDefault;
  localparam int DrainCycles   = 6;
  localparam int WatchdogLimit = 4000;
  localparam int PrintLimit    = 100;

  // One expected result item, in the order of the m_axis tdata fields.
  typedef struct packed {
    logic [PixW-1:0]   pixel_column;
    logic [PixW-1:0]   pixel_row;
    logic [SrcW-1:0]   source_column;
    logic [SrcW-1:0]   source_row;
    logic [PhaseW-1:0] phase_index;
    logic              in_domain;
    logic              end_of_frame;
  } sample_address_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // vector_x, vector_y, slot, slot_width, slot_height, four zero bits.
  logic [InDataW-1:0]  s_axis_tdata = '0;
  // func.
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // pixel_column, pixel_row, source_column, source_row, phase_index, in_domain.
  logic [OutDataW-1:0] m_axis_tdata;
  // end_of_frame.
  logic                m_axis_tlast;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgAddrW-1:0] cfg_addr_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  // Model copy of the configuration, starting at the reset values.
  logic [TsW-1:0]      cur_time_scale    = TsW'(256);
  logic                cur_round_nearest = 1'b0;
  logic [ShW-1:0]      cur_subpel_shift  = '0;
  logic [PadW-1:0]     cur_pad_left      = '0;
  logic [PadW-1:0]     cur_pad_top       = '0;
  logic [DimW-1:0]     cur_frame_columns = DimW'(1);
  logic [DimW-1:0]     cur_frame_rows    = DimW'(1);

  // Model copy of the raster position and of the phase limits.
  logic [PixW-1:0]     raster_col = '0;
  logic [PixW-1:0]     raster_row = '0;
  logic [LimW-1:0]     phase_width  [PhaseSlots];
  logic [LimW-1:0]     phase_height [PhaseSlots];

  sample_address_t     pending_addresses [$];
  int                  error_count = 0;
  int                  quiet_cycles = 0;
  int                  sender_idle_pct = 0;
  int                  receiver_idle_pct = 0;

  motion_vector_subpel_sample_address_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // The receiver stalls at random; the share of stalled cycles is set per phase.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Model of the address arithmetic
  // ---------------------------------------------------------------------------

  function automatic int frame_extent(input logic [DimW-1:0] dim);
    if (dim == 0) return 1;
    if (dim > MaxFrameDim) return MaxFrameDim;
    return int'(dim);
  endfunction

  // Works out the result of one sample item and advances the raster position.
  task automatic predict_sample_address(input logic signed [VecW-1:0] vx,
                                        input logic signed [VecW-1:0] vy,
                                        output sample_address_t res);
    longint rounding, dx, dy, frac_mask, sx, sy;
    int     sh, phase;
    logic   in_range, last_col, last_row;
    sh = (cur_subpel_shift > 2) ? 2 : int'(cur_subpel_shift);
    rounding = cur_round_nearest ? RoundHalf : 0;
    // Arithmetic right shifts of signed values give the floor.
    dx = (longint'(vx) * longint'(cur_time_scale) + rounding) >>> ScaleShift;
    dy = (longint'(vy) * longint'(cur_time_scale) + rounding) >>> ScaleShift;
    frac_mask = (longint'(1) << sh) - 1;
    phase = int'((dx & frac_mask) + ((dy & frac_mask) << sh));
    sx = longint'(cur_pad_left) + longint'(raster_col) + (dx >>> sh);
    sy = longint'(cur_pad_top) + longint'(raster_row) + (dy >>> sh);
    in_range = 1'b0;
    if (phase < PhaseSlots) begin
      in_range = sx >= 0 && sx < longint'(phase_width[phase]) &&
                 sy >= 0 && sy < longint'(phase_height[phase]);
    end
    // A counter at or past the frame edge after a size change counts as the edge.
    last_col = (int'(raster_col) + 1 >= frame_extent(cur_frame_columns));
    last_row = (int'(raster_row) + 1 >= frame_extent(cur_frame_rows));
    res.pixel_column  = raster_col;
    res.pixel_row     = raster_row;
    res.source_column = SrcW'(sx);
    res.source_row    = SrcW'(sy);
    res.phase_index   = PhaseW'(phase);
    res.in_domain     = in_range;
    res.end_of_frame  = last_col && last_row;
    if (last_col) begin
      raster_col = '0;
      raster_row = last_row ? '0 : raster_row + 1'b1;
    end else begin
      raster_col = raster_col + 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_count++;
    if (error_count <= PrintLimit) begin
      $display("%0t: mismatch on %s, got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
  endtask

  task automatic check_field(input string what, input longint got, input longint want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk_i) begin : check_results
    sample_address_t oldest;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_addresses.size() == 0) begin
        report_mismatch("result item with no sample pending", m_axis_tdata, 0);
      end else begin
        oldest = pending_addresses.pop_front();
        check_field("pixel_column", m_axis_tdata[11:0], oldest.pixel_column);
        check_field("pixel_row", m_axis_tdata[23:12], oldest.pixel_row);
        check_field("source_column", m_axis_tdata[40:24], oldest.source_column);
        check_field("source_row", m_axis_tdata[57:41], oldest.source_row);
        check_field("phase_index", m_axis_tdata[61:58], oldest.phase_index);
        check_field("in_domain", m_axis_tdata[62], oldest.in_domain);
        check_field("end_of_frame", m_axis_tlast, oldest.end_of_frame);
      end
    end
  end

  // Ends the run when no handshake of any channel completes for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("motion_vector_subpel_sample_address_core regression: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. Every task starts and ends right after a falling edge.
  // ---------------------------------------------------------------------------

  // Sends one item. tvalid stays high on return so that the next item can follow
  // without a gap; drain_pending lowers it.
  task automatic send_item(input func_e func, input logic signed [VecW-1:0] vx,
                           input logic signed [VecW-1:0] vy, input logic [SlotW-1:0] slot,
                           input logic [LimW-1:0] lim_w, input logic [LimW-1:0] lim_h);
    sample_address_t expected;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {4'b0000, lim_h, lim_w, slot, vy, vx};
    do @(posedge clk_i); while (!s_axis_tready);
    if (func == FuncLoad) begin
      phase_width[slot]  = lim_w;
      phase_height[slot] = lim_h;
    end else begin
      predict_sample_address(vx, vy, expected);
      pending_addresses.push_back(expected);
    end
    @(negedge clk_i);
  endtask

  // Stops sending and waits until every result is back and any trailing load
  // has left the pipeline.
  task automatic drain_pending();
    s_axis_tvalid <= 1'b0;
    while (pending_addresses.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_register(input cfg_reg_e idx, input int value);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= CfgDataW'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegTimeScale:    cur_time_scale    = TsW'(value);
      RegRoundNearest: cur_round_nearest = value[0];
      RegSubpelShift:  cur_subpel_shift  = ShW'(value);
      RegPadLeft:      cur_pad_left      = PadW'(value);
      RegPadTop:       cur_pad_top       = PadW'(value);
      RegFrameColumns: cur_frame_columns = DimW'(value);
      RegFrameRows:    cur_frame_rows    = DimW'(value);
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Writes every register once, only after the pipeline has emptied.
  task automatic configure(input int ts, input int rn, input int sh, input int pl,
                           input int pt, input int cols, input int rows);
    drain_pending();
    write_register(RegTimeScale, ts);
    write_register(RegRoundNearest, rn);
    write_register(RegSubpelShift, sh);
    write_register(RegPadLeft, pl);
    write_register(RegPadTop, pt);
    write_register(RegFrameColumns, cols);
    write_register(RegFrameRows, rows);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Random values
  // ---------------------------------------------------------------------------

  // Mostly short vectors so that sources land near the frame and the limits.
  function automatic logic signed [VecW-1:0] random_vector();
    int v;
    case ($urandom_range(0, 9))
      0:       v = $urandom_range(0, 1) ? 32767 : -32768;
      1:       v = int'($urandom_range(0, 65535)) - 32768;
      2, 3:    v = int'($urandom_range(0, 4096)) - 2048;
      default: v = int'($urandom_range(0, 128)) - 64;
    endcase
    return VecW'(v);
  endfunction

  function automatic logic [LimW-1:0] random_limit();
    case ($urandom_range(0, 9))
      0:          return '0;
      1:          return '1;
      2, 3:       return LimW'($urandom);
      4, 5, 6:    return LimW'($urandom_range(0, 200));
      default:    return LimW'($urandom_range(0, 5000));
    endcase
  endfunction

  // Mostly tiny frames, so that rows wrap and frames end within a burst.
  function automatic int random_dimension();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return MaxFrameDim;
      2:       return 8191;
      3:       return $urandom_range(0, 8191);
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  function automatic int random_pad();
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return 1023;
      2:       return $urandom_range(0, 1023);
      default: return $urandom_range(0, 16);
    endcase
  endfunction

  function automatic int random_time_scale();
    case ($urandom_range(0, 5))
      0:       return 256;
      1:       return 0;
      2:       return 511;
      default: return $urandom_range(0, 511);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Fills every phase entry before any sample can read one.
  task automatic test_phase_table_load();
    for (int slot = 0; slot < PhaseSlots; slot++) begin
      case (slot)
        0:       send_item(FuncLoad, 16'sh7fff, 16'sh8000, SlotW'(slot), '1, '1);
        5:       send_item(FuncLoad, 16'sh8000, 16'sh7fff, SlotW'(slot), '1, '0);
        15:      send_item(FuncLoad, '0, '0, SlotW'(slot), '0, '0);
        default: send_item(FuncLoad, '0, '0, SlotW'(slot),
                           LimW'(64 + slot * 97), LimW'(48 + slot * 61));
      endcase
    end
  endtask

  // Vector extremes, both rounding modes, precision code three and wrapping
  // source positions.
  task automatic test_boundary_addresses();
    configure(256, 0, 0, 0, 0, 2, 2);
    send_item(FuncSample, 16'sd0, 16'sd0, '0, '0, '0);
    send_item(FuncSample, -16'sd1, -16'sd1, '1, '1, '1);
    send_item(FuncSample, 16'sh7fff, 16'sh8000, '0, '0, '0);
    send_item(FuncSample, 16'sd5, 16'sd3, '0, '0, '0);
    // Frame size zero counts as one, so every sample ends a frame. The time
    // scale above 256 and the full padding push sources far outside the frame.
    configure(511, 1, 3, 1023, 1023, 0, 0);
    send_item(FuncSample, 16'sh7fff, 16'sh7fff, '0, '0, '0);
    send_item(FuncSample, 16'sh8000, 16'sh8000, '0, '0, '0);
    send_item(FuncSample, 16'sd3, -16'sd3, '0, '0, '0);
  endtask

  // Oversized frames saturate; shrinking the frame under a running counter
  // makes that counter the last column.
  task automatic test_frame_size_limits();
    configure(0, 0, 1, 0, 0, 8191, 8191);
    send_item(FuncSample, 16'sh8000, 16'sh7fff, '0, '0, '0);
    send_item(FuncSample, 16'sd7, -16'sd9, '0, '0, '0);
    configure(128, 0, 2, 0, 0, 1, MaxFrameDim);
    send_item(FuncSample, -16'sd5, 16'sd6, '0, '0, '0);
    send_item(FuncSample, 16'sd100, -16'sd100, '0, '0, '0);
  endtask

  // Bursts of random items, each under a fresh random setting. Every burst
  // starts with a full drain, which also exercises the paused sender.
  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int item_count);
    int sent;
    sender_idle_pct   = send_pct;
    receiver_idle_pct = recv_pct;
    sent = 0;
    while (sent < item_count) begin
      configure(random_time_scale(), $urandom_range(0, 1), $urandom_range(0, 3),
                random_pad(), random_pad(), random_dimension(), random_dimension());
      repeat ($urandom_range(20, 60)) begin
        send_item(($urandom_range(0, 99) < 15) ? FuncLoad : FuncSample,
                  random_vector(), random_vector(), SlotW'($urandom_range(0, 15)),
                  random_limit(), random_limit());
        sent++;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_phase_table_load();
    test_boundary_addresses();
    test_frame_size_limits();
    test_random_traffic(38, 79, 470);
    test_random_traffic(79, 38, 470);
    test_random_traffic(0, 0, 470);
    drain_pending();
    repeat (10) @(negedge clk_i);
    if (error_count == 0) begin
      $display("motion_vector_subpel_sample_address_core regression: pass");
    end else begin
      $display("motion_vector_subpel_sample_address_core regression: fail");
    end
    $finish;
  end

endmodule

FILE: motion_vector_subpel_sample_address_core.f
+incdir+hw/rtl
hw/rtl/mvsa_pkg.sv
hw/rtl/mvsa_raster.sv
hw/rtl/mvsa_phase_table.sv
hw/rtl/motion_vector_subpel_sample_address_core.sv
dv/tb_motion_vector_subpel_sample_address_core.sv
